// ===== src/sha_pkg.sv =====
// Shared types, constants and round constants of the SHA-256 message hasher.
`timescale 1ns / 1ps

package sha_pkg;

	typedef logic [0:7][31:0] sha_hash_t;

	typedef enum logic {
		OP_ABSORB = 1'b0,
		OP_FINISH = 1'b1
	} sha_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_OUT
	} sha_state_t;

	typedef struct packed {
		logic       shift_en;
		logic [7:0] shift_byte;
		logic       start;
	} sha_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} sha_stat_t;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST  = 3'd7;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	localparam sha_hash_t HASH_INIT = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== src/sha_core.sv =====
// Block buffer, message schedule window and iterative SHA-256 round unit.
`timescale 1ns / 1ps

module sha_core
	import sha_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sha_ctrl_t ctrl,
	input  sha_hash_t hash_in,
	output sha_stat_t stat,
	output sha_hash_t work_out
);

	logic [511:0] win_q;
	sha_hash_t    v_q;
	logic [5:0]   rnd_q;
	logic         busy_q;
	logic         done_q;

	logic [31:0] w_t, w_t1, w_t9, w_t14, w_new;
	logic [31:0] s0, s1, big0, big1, ch, maj, t1, t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		w_t   = win_q[511:480];
		w_t1  = win_q[479:448];
		w_t9  = win_q[223:192];
		w_t14 = win_q[63:32];
		s0    = rotr(w_t1, 7) ^ rotr(w_t1, 18) ^ (w_t1 >> 3);
		s1    = rotr(w_t14, 17) ^ rotr(w_t14, 19) ^ (w_t14 >> 10);
		w_new = s1 + w_t9 + s0 + w_t;
		big1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		big0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big1 + ch + ROUND_K[rnd_q] + w_t;
		t2    = big0 + maj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= busy_q && (rnd_q == ROUND_LAST);
			if (ctrl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == ROUND_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			win_q <= {win_q[503:0], ctrl.shift_byte};
		end else if (busy_q) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (ctrl.start) begin
			v_q <= hash_in;
		end else if (busy_q) begin
			v_q <= {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign work_out  = v_q;

	a_no_shift_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift_en |-> !busy_q) else $error("block byte shifted in during rounds");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !busy_q) else $error("compression started while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q) && $past(rnd_q) == ROUND_LAST)
		else $error("done without a final round");

endmodule

// ===== src/sha256_message_hasher.sv =====
// Top level of the SHA-256 message hasher: byte intake, padding sequencer and digest output.
// An absorb transaction takes one byte and starts a compression if it completes a block.
// A finish transaction pads one byte per cycle and runs one or two compressions on the shared
// round unit, then sends eight words, one a cycle while out_ready is high.
// The round unit does one round per cycle; the input waits through padding, rounds and output.
// Reset (arst_n low) loads the initial hash words and clears the byte and bit counts.
`timescale 1ns / 1ps

module sha256_message_hasher
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  message_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_state_t  state_q, state_d;
	sha_hash_t   hash_q;
	sha_hash_t   work;
	sha_ctrl_t   ctrl;
	sha_stat_t   stat;
	logic [5:0]  fill_q, fill_d;
	logic [63:0] bits_q, bits_d;
	logic        fin_q, fin_d;
	logic        two_q, two_d;
	logic        final_q, final_d;
	logic [2:0]  idx_q, idx_d;
	logic        hash_add;
	logic        hash_clear;
	logic        in_fire;
	logic        out_fire;

	sha_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.hash_in  (hash_q),
		.stat     (stat),
		.work_out (work)
	);

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign in_fire     = in_valid && in_ready;
	assign out_fire    = out_valid && out_ready;
	assign digest_word = hash_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == WORD_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		bits_d     = bits_q;
		fin_d      = fin_q;
		two_d      = two_q;
		final_d    = final_q;
		idx_d      = idx_q;
		hash_add   = 1'b0;
		hash_clear = 1'b0;
		ctrl       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					ctrl.shift_en = 1'b1;
					fill_d        = fill_q + 6'd1;
					if (operation == OP_FINISH) begin
						ctrl.shift_byte = PAD_BYTE;
						fin_d           = 1'b1;
						final_d         = 1'b0;
						two_d           = (fill_q >= LEN_POS) && (fill_q != BLOCK_LAST);
						state_d         = ST_PAD;
					end else begin
						ctrl.shift_byte = message_byte;
						bits_d          = bits_q + BITS_PER_BYTE;
					end
					if (fill_q == BLOCK_LAST) begin
						ctrl.start = 1'b1;
						state_d    = ST_COMP;
					end
				end
			end
			ST_PAD: begin
				ctrl.shift_en = 1'b1;
				fill_d        = fill_q + 6'd1;
				if (two_q || fill_q < LEN_POS) begin
					ctrl.shift_byte = '0;
				end else begin
					ctrl.shift_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];
				end
				if (fill_q == BLOCK_LAST) begin
					ctrl.start = 1'b1;
					final_d    = !two_q;
					two_d      = 1'b0;
					state_d    = ST_COMP;
				end
			end
			ST_COMP: begin
				if (stat.done) begin
					hash_add = 1'b1;
					if (!fin_q) begin
						state_d = ST_IDLE;
					end else if (final_q) begin
						state_d = ST_OUT;
					end else begin
						state_d = ST_PAD;
					end
				end
			end
			ST_OUT: begin
				if (out_fire) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == WORD_LAST) begin
						hash_clear = 1'b1;
						fill_d     = '0;
						bits_d     = '0;
						fin_d      = 1'b0;
						final_d    = 1'b0;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= HASH_INIT;
			fill_q  <= '0;
			bits_q  <= '0;
			fin_q   <= 1'b0;
			two_q   <= 1'b0;
			final_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			fill_q  <= fill_d;
			bits_q  <= bits_d;
			fin_q   <= fin_d;
			two_q   <= two_d;
			final_q <= final_d;
			idx_q   <= idx_d;
			if (hash_clear) begin
				hash_q <= HASH_INIT;
			end else if (hash_add) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + work[i];
				end
			end
		end
	end

	a_ready_core_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !stat.busy) else $error("input ready while the round unit runs");
	a_done_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == ST_COMP) else $error("compression done outside wait state");
	a_restart_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_word) |=> in_ready && fill_q == '0 && bits_q == '0 && !fin_q)
		else $error("message state not cleared after the digest");
	a_out_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fin_q && final_q) else $error("digest sent before the length block");

endmodule
